// File: rtl/core/ptw_pkg.sv
// Shared types, constants and codes for the two-level page walker.
`default_nettype none
package ptw_pkg;

  // Depth of the entry memory in 32-bit words.
  localparam int TABLE_WORDS = 4096;
  // Word address width of the entry memory.
  localparam int AW = $clog2(TABLE_WORDS);
  // Width of a full entry index: a 20-bit frame number and a 10-bit slot.
  localparam int IDX_W = 30;
  localparam logic [IDX_W-1:0] TABLE_LIMIT = IDX_W'(TABLE_WORDS);

  // Bytes in one page, one bit wider than the page offset.
  localparam logic [12:0] PAGE_BYTES = 13'd4096;

  // Entry bit positions.
  localparam int BIT_PRESENT  = 0;
  localparam int BIT_ACCESSED = 5;
  localparam int BIT_DIRTY    = 6;

  // Item opcodes.
  localparam logic [1:0] OP_TRANSLATE = 2'd0;
  localparam logic [1:0] OP_WRITE     = 2'd1;
  localparam logic [1:0] OP_READ      = 2'd2;

  // Result status codes.
  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_CROSS      = 3'd1;
  localparam logic [2:0] STAT_DIR_ABSENT = 3'd2;
  localparam logic [2:0] STAT_TAB_ABSENT = 3'd3;
  localparam logic [2:0] STAT_RANGE      = 3'd4;

  // Register addresses on the configuration port.
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_BASE   = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PDE,
    S_PTE,
    S_RDW,
    S_OUT
  } ptw_state_t;

  // Read and write requests to the entry memory.
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    logic [AW-1:0] raddr;
  } ptw_ram_req_t;

endpackage
`default_nettype wire

// File: rtl/core/two_level_page_walker_top.sv
// Top level of the two-level page walker: register port, sequencer and entry memory.
//
//  channel   dir  handshake             contents
//  s_*       in   s_tvalid / s_tready   request word: opcode in tuser, fields in tdata
//  m_*       out  m_tvalid / m_tready   result word: status in tuser, addresses in tdata
//  apb       in   psel/penable/pwrite   translate_enable at 0x0, directory_base at 0x4
//
// A full translation passes S_PDE, S_PTE and S_OUT, which loads the result into the output
// register: two dependent reads of the single entry memory, writebacks sharing its write
// port. A walk stopped after the directory entry passes S_PDE and S_OUT, a readback S_RDW
// and S_OUT; other items go straight to S_OUT. One item is in flight at a time; a held result
// does not block the next acceptance, which then waits until the output register frees.
// Reset is synchronous and clears control state only; the entry memory is never cleared.
`default_nettype none
module two_level_page_walker_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tdata: virtual_address[31:0], is_write[32], access_length[35:33],
  //        word_index[47:36], word_data[79:48]
  input  wire logic [79:0] s_tdata,
  // tuser: opcode[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // tdata: physical_address[31:0], word_out[63:32]
  output logic [63:0]      m_tdata,
  // tuser: status[2:0]
  output logic [2:0]       m_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ptw_pkg::*;

  logic         translate_enable;
  logic [19:0]  directory_base;
  logic         reg_wr;
  ptw_ram_req_t ram_req;
  logic [31:0]  ram_rdata;

  // Configuration registers.
  always_comb begin
    pready = 1'b1;
    reg_wr = psel && penable && pwrite && pready;
    prdata = (paddr[2] == REG_BASE) ? {12'd0, directory_base}
                                    : {31'd0, translate_enable};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      translate_enable <= 1'b0;
      directory_base   <= '0;
    end else if (reg_wr) begin
      if (paddr[2] == REG_ENABLE) begin
        translate_enable <= pwdata[0];
      end else begin
        directory_base <= pwdata[19:0];
      end
    end
  end

  ptw_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tuser          (s_tuser),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tuser          (m_tuser),
    .translate_enable (translate_enable),
    .directory_base   (directory_base),
    .ram_req          (ram_req),
    .ram_rdata        (ram_rdata)
  );

  ptw_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // An error result never carries a physical address.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata[31:0] == 32'd0))
    else $error("error result with nonzero physical address");

  // A readback word only comes with a good status.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[63:32] != 32'd0) |-> (m_tuser == STAT_OK))
    else $error("readback word with error status");

  // Every accepted word occupies the sequencer, which drops s_tready before it can take another.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted on consecutive cycles");

  // The entry memory is only written while a word is being taken or walked.
  assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> (s_tvalid && s_tready) || !s_tready)
    else $error("memory write outside an item");
endmodule
`default_nettype wire

// File: rtl/core/ptw_idx.sv
// Shared entry index unit: forms frame:slot and checks it against the memory depth.
`default_nettype none
module ptw_idx (
  input  wire logic [19:0]             base,
  input  wire logic [9:0]              slot,
  output logic [ptw_pkg::AW-1:0]       idx,
  output logic                         in_range
);
  import ptw_pkg::*;

  logic [IDX_W-1:0] full;

  // The frame number scaled by 1024 words plus the slot is a plain concatenation.
  always_comb begin
    full     = {base, slot};
    in_range = full < TABLE_LIMIT;
    idx      = full[AW-1:0];
  end
endmodule
`default_nettype wire

// File: rtl/core/ptw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module ptw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/core/ptw_ctrl.sv
// Walk sequencer: accepts items, steps the two entry reads and writebacks, holds the result.
`default_nettype none
module ptw_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // tdata: virtual_address[31:0], is_write[32], access_length[35:33],
  //        word_index[47:36], word_data[79:48]
  input  wire logic [79:0]           s_tdata,
  // tuser: opcode[1:0]
  input  wire logic [1:0]            s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // tdata: physical_address[31:0], word_out[63:32]
  output logic [63:0]                m_tdata,
  // tuser: status[2:0]
  output logic [2:0]                 m_tuser,
  input  wire logic                  translate_enable,
  input  wire logic [19:0]           directory_base,
  output ptw_pkg::ptw_ram_req_t      ram_req,
  input  wire logic [31:0]           ram_rdata
);
  import ptw_pkg::*;

  ptw_state_t state, state_next;

  logic [31:0]   va, va_next;
  logic          wr, wr_next;
  logic [AW-1:0] di, di_next;
  logic [AW-1:0] ti, ti_next;
  logic [31:0]   pde, pde_next;
  logic          same, same_next;
  logic [31:0]   res_pa, res_pa_next;
  logic [2:0]    res_st, res_st_next;
  logic [31:0]   res_word, res_word_next;
  logic          m_valid_next;
  logic [63:0]   m_data_next;
  logic [2:0]    m_user_next;

  // Shared index unit ports.
  logic [19:0]   u_base;
  logic [9:0]    u_slot;
  logic [AW-1:0] u_idx;
  logic          u_ok;

  // Fields of the incoming word.
  logic [31:0]   in_va;
  logic          in_wr;
  logic [2:0]    in_len;
  logic [11:0]   in_widx;
  logic [31:0]   in_wdata;
  logic          in_cross;
  logic          in_widx_ok;
  logic [31:0]   pte;
  logic          out_free;

  ptw_idx u_index (
    .base     (u_base),
    .slot     (u_slot),
    .idx      (u_idx),
    .in_range (u_ok)
  );

  // Unpack the input word and the cheap checks on it.
  always_comb begin
    in_va      = s_tdata[31:0];
    in_wr      = s_tdata[32];
    in_len     = s_tdata[35:33];
    in_widx    = s_tdata[47:36];
    in_wdata   = s_tdata[79:48];
    in_cross   = ({1'b0, in_va[11:0]} + {10'b0, in_len}) > PAGE_BYTES;
    in_widx_ok = {{(IDX_W-12){1'b0}}, in_widx} < TABLE_LIMIT;
    out_free   = !m_tvalid || m_tready;
    // A table entry in the same word as its directory entry sees the accessed bit.
    pte        = same ? pde : ram_rdata;
  end

  // State and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_valid_next;
    end
    va       <= va_next;
    wr       <= wr_next;
    di       <= di_next;
    ti       <= ti_next;
    pde      <= pde_next;
    same     <= same_next;
    res_pa   <= res_pa_next;
    res_st   <= res_st_next;
    res_word <= res_word_next;
    m_tdata  <= m_data_next;
    m_tuser  <= m_user_next;
  end

  // Next state, memory requests and result.
  always_comb begin
    state_next    = state;
    va_next       = va;
    wr_next       = wr;
    di_next       = di;
    ti_next       = ti;
    pde_next      = pde;
    same_next     = same;
    res_pa_next   = res_pa;
    res_st_next   = res_st;
    res_word_next = res_word;
    m_valid_next  = m_tvalid && !m_tready;
    m_data_next   = m_tdata;
    m_user_next   = m_tuser;
    s_tready      = 1'b0;
    ram_req       = '0;
    u_base        = directory_base;
    u_slot        = in_va[31:22];

    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          va_next       = in_va;
          wr_next       = in_wr;
          res_pa_next   = '0;
          res_st_next   = STAT_OK;
          res_word_next = '0;
          state_next    = S_OUT;
          case (s_tuser)
            OP_TRANSLATE: begin
              if (in_cross) begin
                res_st_next = STAT_CROSS;
              end else if (!translate_enable) begin
                res_pa_next = in_va;
              end else if (!u_ok) begin
                res_st_next = STAT_RANGE;
              end else begin
                ram_req.raddr = u_idx;
                di_next       = u_idx;
                state_next    = S_PDE;
              end
            end
            OP_WRITE: begin
              if (!in_widx_ok) begin
                res_st_next = STAT_RANGE;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = AW'(in_widx);
                ram_req.wdata = in_wdata;
              end
            end
            OP_READ: begin
              if (!in_widx_ok) begin
                res_st_next = STAT_RANGE;
              end else begin
                ram_req.raddr = AW'(in_widx);
                state_next    = S_RDW;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Directory entry is on the read port: if present, mark it and fetch the table entry.
      S_PDE: begin
        u_base     = ram_rdata[31:12];
        u_slot     = va[21:12];
        state_next = S_OUT;
        if (!ram_rdata[BIT_PRESENT]) begin
          res_st_next = STAT_DIR_ABSENT;
        end else begin
          ram_req.we    = 1'b1;
          ram_req.waddr = di;
          ram_req.wdata = ram_rdata | (32'd1 << BIT_ACCESSED);
          pde_next      = ram_rdata | (32'd1 << BIT_ACCESSED);
          if (!u_ok) begin
            res_st_next = STAT_RANGE;
          end else begin
            ram_req.raddr = u_idx;
            ti_next       = u_idx;
            same_next     = (u_idx == di);
            state_next    = S_PTE;
          end
        end
      end

      // Table entry is available: if present, mark it and form the physical address.
      S_PTE: begin
        state_next = S_OUT;
        if (!pte[BIT_PRESENT]) begin
          res_st_next = STAT_TAB_ABSENT;
        end else begin
          ram_req.we    = 1'b1;
          ram_req.waddr = ti;
          ram_req.wdata = pte | (32'd1 << BIT_ACCESSED) | ({31'd0, wr} << BIT_DIRTY);
          res_pa_next   = {pte[31:12], va[11:0]};
        end
      end

      // Readback word is on the read port.
      S_RDW: begin
        res_word_next = ram_rdata;
        state_next    = S_OUT;
      end

      // Hand the result to the output register once it is free.
      S_OUT: begin
        if (out_free) begin
          m_valid_next = 1'b1;
          m_data_next  = {res_word, res_pa};
          m_user_next  = res_st;
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire
